// ----- design/hfc_pkg.sv -----
// hfc_pkg: shared widths, register indexes, reset values and types of the
// heater and fan run timer; no dependencies
package hfc_pkg;

    localparam int TIME_BITS   = 25;
    localparam int WIDE_W      = 33;

    localparam int MODE_W      = 2;
    localparam int NOW_W       = 32;
    localparam int TEMP_W      = 11;
    localparam int HUM_W       = 10;
    localparam int MIN_W       = 9;
    localparam int HOLDOFF_W   = 16;
    localparam int STEP_W      = 22;
    localparam int LIMIT_W     = 25;
    localparam int STOP_W      = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_ON_TEMP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMIDITY_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HOLDOFF_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_LIMIT_MS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME_MS     = 3'd5;

    localparam logic signed [TEMP_W-1:0] HEAT_ON_TEMP_RST     = 11'sd185;
    localparam logic [HUM_W-1:0]         HUMIDITY_LIMIT_RST   = 10'd800;
    localparam logic [HOLDOFF_W-1:0]     PRESS_HOLDOFF_MS_RST = 16'd1000;
    localparam logic [STEP_W-1:0]        TIME_STEP_MS_RST     = 22'd3600000;
    localparam logic [LIMIT_W-1:0]       ADD_LIMIT_MS_RST     = 25'd18000000;
    localparam logic [STOP_W-1:0]        STOP_TIME_MS_RST     = 22'd60000;

    // minutes = (ms >> 5) / 1875, the odd part by reciprocal multiply
    localparam int               MIN_SHIFT   = 5;
    localparam longint unsigned  DIV_ODD     = 1875;
    localparam int               RECIP_SHIFT = 40;
    localparam longint unsigned  RECIP       = ((64'd1 << RECIP_SHIFT) + DIV_ODD - 1) / DIV_ODD;
    localparam int               RECIP_W     = 30;
    localparam int               MINUTES_MAX = 511;

    typedef enum logic [MODE_W-1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_READING = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [NOW_W-1:0]         now_ms;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic                     reading_valid;
    } hfc_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } hfc_qstat_t;

endpackage

// ----- design/hfc_ifs.sv -----
// hfc_in_if and hfc_out_if: valid/ready channels for input and result words
// depends on hfc_pkg
interface hfc_in_if;
    logic                              valid;
    logic                              ready;
    logic [hfc_pkg::MODE_W-1:0]        mode;
    logic [hfc_pkg::NOW_W-1:0]         now_ms;
    logic signed [hfc_pkg::TEMP_W-1:0] temperature;
    logic [hfc_pkg::HUM_W-1:0]         humidity;
    logic                              reading_valid;

    modport source (output valid, mode, now_ms, temperature, humidity, reading_valid,
                    input ready);
    modport sink (input valid, mode, now_ms, temperature, humidity, reading_valid,
                  output ready);
endinterface

interface hfc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        heater_on;
    logic                        fan_on;
    logic [hfc_pkg::MIN_W-1:0]   minutes_left;
    logic                        press_accepted;

    modport source (output valid, heater_on, fan_on, minutes_left, press_accepted,
                    input ready);
    modport sink (input valid, heater_on, fan_on, minutes_left, press_accepted,
                  output ready);
endinterface

// ----- design/hfc_front.sv -----
// hfc_front: accepts input words, classifies the mode and queues them
// depends on hfc_pkg and hfc_in_if
module hfc_front (
    input  logic                clk,
    input  logic                rst_n,
    hfc_in_if.sink              in_ch,
    input  logic                pop,
    output hfc_pkg::hfc_item_t  q_item,
    output hfc_pkg::hfc_qstat_t q_stat
);
    import hfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    hfc_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    hfc_item_t        new_item;

    assign in_ch.ready = (count_reg != CNT_FULL);
    assign push        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        new_item.op            = op_t'(in_ch.mode);
        new_item.now_ms        = in_ch.now_ms;
        new_item.temperature   = in_ch.temperature;
        new_item.humidity      = in_ch.humidity;
        new_item.reading_valid = in_ch.reading_valid;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign q_item       = slot_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == CNT_FULL);

endmodule

// ----- design/hfc_back.sv -----
// hfc_back: configuration registers, run timer and thermostat state,
// result register and minutes conversion; depends on hfc_pkg and hfc_out_if
module hfc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hfc_pkg::hfc_item_t             q_item,
    input  hfc_pkg::hfc_qstat_t            q_stat,
    output logic                           pop,
    input  logic                           cfg_we,
    input  logic [hfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfc_pkg::CFG_DATA_W-1:0] cfg_data,
    hfc_out_if.source                      out_ch
);
    import hfc_pkg::*;

    localparam logic [WIDE_W-1:0] TIME_MAX = WIDE_W'((64'd1 << TIME_BITS) - 1);
    localparam int X_W    = TIME_BITS - MIN_SHIFT;
    localparam int PROD_W = X_W + RECIP_W;
    localparam int QUO_W  = PROD_W - RECIP_SHIFT;

    logic signed [TEMP_W-1:0] heat_on_temp_reg;
    logic [HUM_W-1:0]         humidity_limit_reg;
    logic [HOLDOFF_W-1:0]     press_holdoff_ms_reg;
    logic [STEP_W-1:0]        time_step_ms_reg;
    logic [LIMIT_W-1:0]       add_limit_ms_reg;
    logic [STOP_W-1:0]        stop_time_ms_reg;

    logic [TIME_BITS-1:0]     remaining_reg, remaining_next;
    logic [NOW_W-1:0]         last_tick_reg, last_tick_next;
    logic [NOW_W-1:0]         last_press_reg, last_press_next;
    logic signed [TEMP_W-1:0] stored_temp_reg, stored_temp_next;
    logic [HUM_W-1:0]         stored_hum_reg, stored_hum_next;
    logic                     heater_reg, heater_next;
    logic                     fan_reg, fan_next;
    logic                     accepted;

    logic                     out_valid_reg;
    logic                     out_heater_reg;
    logic                     out_fan_reg;
    logic                     out_acc_reg;
    logic [TIME_BITS-1:0]     out_rem_reg;

    logic [NOW_W-1:0]         elapsed;
    logic [NOW_W-1:0]         since_press;
    logic [WIDE_W-1:0]        rem_wide;
    logic [WIDE_W-1:0]        sum_wide;
    logic [WIDE_W-1:0]        stop_wide;

    logic [X_W-1:0]           div_x;
    logic [PROD_W-1:0]        div_prod;
    logic [QUO_W-1:0]         div_quo;

    assign pop = q_stat.valid && (!out_valid_reg || out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_on_temp_reg     <= HEAT_ON_TEMP_RST;
            humidity_limit_reg   <= HUMIDITY_LIMIT_RST;
            press_holdoff_ms_reg <= PRESS_HOLDOFF_MS_RST;
            time_step_ms_reg     <= TIME_STEP_MS_RST;
            add_limit_ms_reg     <= ADD_LIMIT_MS_RST;
            stop_time_ms_reg     <= STOP_TIME_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAT_ON_TEMP:     heat_on_temp_reg     <= signed'(cfg_data[TEMP_W-1:0]);
                CFG_HUMIDITY_LIMIT:   humidity_limit_reg   <= cfg_data[HUM_W-1:0];
                CFG_PRESS_HOLDOFF_MS: press_holdoff_ms_reg <= cfg_data[HOLDOFF_W-1:0];
                CFG_TIME_STEP_MS:     time_step_ms_reg     <= cfg_data[STEP_W-1:0];
                CFG_ADD_LIMIT_MS:     add_limit_ms_reg     <= cfg_data[LIMIT_W-1:0];
                CFG_STOP_TIME_MS:     stop_time_ms_reg     <= cfg_data[STOP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign elapsed     = q_item.now_ms - last_tick_reg;
    assign since_press = q_item.now_ms - last_press_reg;
    assign rem_wide    = WIDE_W'(remaining_reg);
    assign sum_wide    = rem_wide + WIDE_W'(time_step_ms_reg);
    assign stop_wide   = WIDE_W'(stop_time_ms_reg);

    always_comb
    begin
        remaining_next   = remaining_reg;
        last_tick_next   = last_tick_reg;
        last_press_next  = last_press_reg;
        stored_temp_next = stored_temp_reg;
        stored_hum_next  = stored_hum_reg;
        heater_next      = heater_reg;
        fan_next         = fan_reg;
        accepted         = 1'b0;
        case (q_item.op)
            OP_TICK:
            begin
                if (WIDE_W'(elapsed) >= rem_wide)
                begin
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - elapsed[TIME_BITS-1:0];
                end
                last_tick_next = q_item.now_ms;
                fan_next       = (remaining_next != '0);
                if (remaining_next == '0)
                begin
                    heater_next = 1'b0;
                end
            end
            OP_PRESS:
            begin
                if (since_press > NOW_W'(press_holdoff_ms_reg))
                begin
                    if (rem_wide < WIDE_W'(add_limit_ms_reg))
                    begin
                        remaining_next = (sum_wide > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                               : sum_wide[TIME_BITS-1:0];
                        accepted       = 1'b1;
                    end
                    last_press_next = q_item.now_ms;
                end
            end
            OP_READING:
            begin
                if (q_item.reading_valid)
                begin
                    stored_temp_next = q_item.temperature;
                    stored_hum_next  = q_item.humidity;
                end
                if (rem_wide > WIDE_W'(1))
                begin
                    heater_next = (stored_temp_next < heat_on_temp_reg) ||
                                  (stored_hum_next > humidity_limit_reg);
                end
                else
                begin
                    heater_next = 1'b0;
                    fan_next    = 1'b0;
                end
            end
            OP_STOP:
            begin
                remaining_next = (stop_wide > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0]
                                                        : stop_wide[TIME_BITS-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg   <= '0;
            last_tick_reg   <= '0;
            last_press_reg  <= '0;
            stored_temp_reg <= '0;
            stored_hum_reg  <= '0;
            heater_reg      <= 1'b0;
            fan_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                remaining_reg   <= remaining_next;
                last_tick_reg   <= last_tick_next;
                last_press_reg  <= last_press_next;
                stored_temp_reg <= stored_temp_next;
                stored_hum_reg  <= stored_hum_next;
                heater_reg      <= heater_next;
                fan_reg         <= fan_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_heater_reg <= heater_next;
            out_fan_reg    <= fan_next;
            out_acc_reg    <= accepted;
            out_rem_reg    <= remaining_next;
        end
    end

    // whole minutes from the held remaining time
    assign div_x    = out_rem_reg[TIME_BITS-1:MIN_SHIFT];
    assign div_prod = PROD_W'(div_x) * PROD_W'(RECIP);
    assign div_quo  = div_prod[PROD_W-1:RECIP_SHIFT];

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.heater_on      = out_heater_reg;
    assign out_ch.fan_on         = out_fan_reg;
    assign out_ch.press_accepted = out_acc_reg;
    assign out_ch.minutes_left   = (WIDE_W'(div_quo) > WIDE_W'(MINUTES_MAX)) ? MIN_W'(MINUTES_MAX)
                                                                             : MIN_W'(div_quo);

endmodule

// ----- design/heater_fan_timer_controller.sv -----
// heater_fan_timer_controller: an input word reaches the result word through the
// queue slot, then the result register
// throughput is one word per cycle while the result word is not stalled
// the two-entry queue lets input and output stall independently
// reset is asynchronous: timer and thermostat state clear, registers take defaults
// depends on hfc_pkg, hfc_ifs, hfc_front and hfc_back
module heater_fan_timer_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    hfc_in_if.sink                         in_ch,
    hfc_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [hfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hfc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hfc_pkg::*;

    hfc_item_t  q_item;
    hfc_qstat_t q_stat;
    logic       pop;

    hfc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .pop    (pop),
        .q_item (q_item),
        .q_stat (q_stat)
    );

    hfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_stat    (q_stat),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ch    (out_ch)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.valid)
        else $error("queue popped while empty");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !in_ch.ready)
        else $error("input ready while queue full");

    a_stalled_output_holds_back: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !pop)
        else $error("back end advanced while result word stalled");

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_ch.valid)
        else $error("processed word did not reach the output");
`endif

endmodule
